[hdl/pltu_pkg.sv]
// ----------------------------------------------------------------------------
// pltu_pkg: shared types and constants of the positional list table
// Word layouts, operation codes and the command/status bundles that join the
// controller to the datapath.
// ----------------------------------------------------------------------------
package pltu_pkg;

    localparam int CAPACITY = 64;
    localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int FUNC_W   = 3;
    localparam int POS_W    = 7;
    localparam int LEN_W    = 7;
    localparam int DATA_W   = 32;
    localparam int CMP_W    = 8;

    localparam logic [FUNC_W-1:0] FUNC_INSERT = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_DELETE = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_GET    = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_LOCATE = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 3'd4;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    typedef struct packed {
        logic [FUNC_W-1:0]        func;
        logic [POS_W-1:0]         position;
        logic signed [DATA_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic                     status;
        logic signed [DATA_W-1:0] out_value;
        logic [POS_W-1:0]         out_position;
        logic [LEN_W-1:0]         length;
        logic                     empty_res;
    } t_out_item;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic ptr_init_last;
        logic ptr_init_pos;
        logic ptr_init_zero;
        logic ptr_inc;
        logic ptr_dec;
        logic rd;
        logic wr_up;
        logic wr_dn;
        logic wr_value;
        logic cap_val;
        logic cap_pos;
        logic cnt_inc;
        logic cnt_dec;
        logic cnt_clr;
        logic set_ok;
        logic out_load;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              ins_ok;
        logic              rd_ok;
        logic              append;
        logic              cnt_zero;
        logic              ptr_at_pos;
        logic              ptr_at_last;
        logic              rd_last;
        logic              rd_vld;
        logic              match;
        logic              out_free;
    } t_dp_sts;

endpackage

[hdl/positional_list_table_unit.sv]
// ----------------------------------------------------------------------------
// positional_list_table_unit: ordered list with insert/delete by position
// Holds up to CAPACITY signed words in order; insert, delete, get, locate and
// clear, one result word per operation.
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | word
//  in      | in        | i_in_valid / o_in_stall | t_in_item  (func, position, value)
//  out     | out       | o_out_valid / i_out_stall | t_out_item (status .. empty_res)
//
//  One operation at a time: decode, the work below, then hand-off. Get reads
//  and captures; insert shifts elements P..N up (none for an append); delete
//  shifts the later ones down; locate scans at most N (N length, P position).
//  The element memory, one write and one read port, moves one element per cycle.
//  Reset clears the length and all handshake state; the store needs no clear.
//  A stalled result sits in the output register; the next word is taken
//  while it waits and is held in its final state until that register frees.
// ----------------------------------------------------------------------------
module positional_list_table_unit
    import pltu_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    pltu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd)
    );

    pltu_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (dp_cmd),
        .o_sts       (dp_sts),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

[hdl/pltu_datapath.sv]
// ----------------------------------------------------------------------------
// pltu_datapath: element store, length, pointer and result registers
// Carries out the controller's commands one per cycle; the store is a single
// write, single registered-read memory.
// ----------------------------------------------------------------------------
module pltu_datapath
    import pltu_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_in_data,
    input  t_dp_cmd   i_cmd,
    output t_dp_sts   o_sts,
    input  logic      i_out_stall,
    output logic      o_out_valid,
    output t_out_item o_out_data
);

    logic [DATA_W-1:0] r_mem [CAPACITY];

    logic [FUNC_W-1:0]        r_func;
    logic [POS_W-1:0]         r_pos_m1;
    logic [DATA_W-1:0]        r_value;
    logic [CNT_W-1:0]         r_cnt;
    logic [CNT_W-1:0]         n_cnt;
    logic [ADDR_W-1:0]        r_ptr;
    logic [ADDR_W-1:0]        r_rd_idx;
    logic                     r_rd_vld;
    logic [DATA_W-1:0]        r_rd_data;
    logic                     r_status;
    logic [DATA_W-1:0]        r_res_value;
    logic [POS_W-1:0]         r_res_pos;
    logic                     r_out_valid;
    t_out_item                r_out_data;

    logic [ADDR_W-1:0]        wr_addr;
    logic [DATA_W-1:0]        wr_data;
    logic                     wr_en;
    logic [CMP_W-1:0]         cnt_x;
    logic [CMP_W-1:0]         pos_x;
    logic [CMP_W-1:0]         last_x;

    assign cnt_x  = CMP_W'(r_cnt);
    assign pos_x  = CMP_W'(r_pos_m1);
    assign last_x = cnt_x - CMP_W'(1);

    always_comb begin
        o_sts.func        = r_func;
        o_sts.ins_ok      = (cnt_x < CMP_W'(CAPACITY)) && (pos_x <= cnt_x);
        o_sts.rd_ok       = pos_x < cnt_x;
        o_sts.append      = pos_x == cnt_x;
        o_sts.cnt_zero    = r_cnt == '0;
        o_sts.ptr_at_pos  = CMP_W'(r_ptr) == pos_x;
        o_sts.ptr_at_last = CMP_W'(r_ptr) == last_x;
        o_sts.rd_last     = CMP_W'(r_rd_idx) == last_x;
        o_sts.rd_vld      = r_rd_vld;
        o_sts.match       = r_rd_vld && (r_rd_data == r_value);
        o_sts.out_free    = !r_out_valid || !i_out_stall;
    end

    // single write port: shifted word or the inserted value
    always_comb begin
        wr_en   = i_cmd.wr_up || i_cmd.wr_dn || i_cmd.wr_value;
        wr_data = r_rd_data;
        wr_addr = ADDR_W'(r_pos_m1);
        priority if (i_cmd.wr_value) begin
            wr_data = r_value;
            wr_addr = ADDR_W'(r_pos_m1);
        end else if (i_cmd.wr_up) begin
            wr_addr = ADDR_W'(r_rd_idx + 1'b1);
        end else if (i_cmd.wr_dn) begin
            wr_addr = ADDR_W'(r_rd_idx - 1'b1);
        end else begin
            wr_addr = ADDR_W'(r_pos_m1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd) begin
            r_rd_data <= r_mem[r_ptr];
            r_rd_idx  <= r_ptr;
        end
    end

    always_comb begin
        n_cnt = r_cnt;
        priority if (i_cmd.cnt_clr) begin
            n_cnt = '0;
        end else if (i_cmd.cnt_inc) begin
            n_cnt = r_cnt + 1'b1;
        end else if (i_cmd.cnt_dec) begin
            n_cnt = r_cnt - 1'b1;
        end else begin
            n_cnt = r_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_cnt    <= n_cnt;
            r_rd_vld <= i_cmd.rd;
        end
    end

    always_ff @(posedge i_clk) begin
        priority if (i_cmd.ptr_init_last) begin
            r_ptr <= ADDR_W'(r_cnt - 1'b1);
        end else if (i_cmd.ptr_init_pos) begin
            r_ptr <= ADDR_W'(r_pos_m1);
        end else if (i_cmd.ptr_init_zero) begin
            r_ptr <= '0;
        end else if (i_cmd.ptr_inc) begin
            r_ptr <= r_ptr + 1'b1;
        end else if (i_cmd.ptr_dec) begin
            r_ptr <= r_ptr - 1'b1;
        end else begin
            r_ptr <= r_ptr;
        end
    end

    // operation word and result fields
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func      <= i_in_data.func;
            r_pos_m1    <= (i_in_data.position == '0) ? '0
                                                      : i_in_data.position - 1'b1;
            r_value     <= i_in_data.value;
            r_status    <= STATUS_ERR;
            r_res_value <= '0;
            r_res_pos   <= '0;
        end else begin
            if (i_cmd.set_ok) begin
                r_status <= STATUS_OK;
            end
            if (i_cmd.cap_val) begin
                r_res_value <= r_rd_data;
            end
            if (i_cmd.cap_pos) begin
                r_res_pos <= POS_W'(r_rd_idx) + 1'b1;
            end
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data.status       <= r_status;
            r_out_data.out_value    <= r_res_value;
            r_out_data.out_position <= r_res_pos;
            r_out_data.length       <= LEN_W'(r_cnt);
            r_out_data.empty_res    <= r_cnt == '0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

[hdl/pltu_ctrl.sv]
// ----------------------------------------------------------------------------
// pltu_ctrl: operation sequencer
// Decodes each accepted word and steps the datapath through reads, shifts,
// scans and the final result hand-off.
// ----------------------------------------------------------------------------
module pltu_ctrl
    import pltu_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_DECODE  = 4'd1;
    localparam logic [3:0] S_UP      = 4'd2;
    localparam logic [3:0] S_UP_END  = 4'd3;
    localparam logic [3:0] S_PUT     = 4'd4;
    localparam logic [3:0] S_GET_RD  = 4'd5;
    localparam logic [3:0] S_GET_CAP = 4'd6;
    localparam logic [3:0] S_DEL_RD  = 4'd7;
    localparam logic [3:0] S_DEL_CAP = 4'd8;
    localparam logic [3:0] S_DN      = 4'd9;
    localparam logic [3:0] S_DN_END  = 4'd10;
    localparam logic [3:0] S_DEL_END = 4'd11;
    localparam logic [3:0] S_LOC     = 4'd12;
    localparam logic [3:0] S_LOC_END = 4'd13;
    localparam logic [3:0] S_DONE    = 4'd14;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = r_state != S_IDLE;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_DONE;
                unique case (i_sts.func)
                    FUNC_INSERT: begin
                        if (i_sts.ins_ok) begin
                            if (i_sts.append) begin
                                n_state = S_PUT;
                            end else begin
                                o_cmd.ptr_init_last = 1'b1;
                                n_state             = S_UP;
                            end
                        end
                    end
                    FUNC_DELETE: begin
                        if (i_sts.rd_ok) begin
                            o_cmd.ptr_init_pos = 1'b1;
                            n_state            = S_DEL_RD;
                        end
                    end
                    FUNC_GET: begin
                        if (i_sts.rd_ok) begin
                            o_cmd.ptr_init_pos = 1'b1;
                            n_state            = S_GET_RD;
                        end
                    end
                    FUNC_LOCATE: begin
                        o_cmd.set_ok = 1'b1;
                        if (!i_sts.cnt_zero) begin
                            o_cmd.ptr_init_zero = 1'b1;
                            n_state             = S_LOC;
                        end
                    end
                    FUNC_CLEAR: begin
                        o_cmd.set_ok  = 1'b1;
                        o_cmd.cnt_clr = 1'b1;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            // move elements up from the tail, read one, write the one before
            S_UP: begin
                o_cmd.rd    = 1'b1;
                o_cmd.wr_up = i_sts.rd_vld;
                if (i_sts.ptr_at_pos) begin
                    n_state = S_UP_END;
                end else begin
                    o_cmd.ptr_dec = 1'b1;
                end
            end
            S_UP_END: begin
                o_cmd.wr_up = 1'b1;
                n_state     = S_PUT;
            end
            S_PUT: begin
                o_cmd.wr_value = 1'b1;
                o_cmd.cnt_inc  = 1'b1;
                o_cmd.set_ok   = 1'b1;
                n_state        = S_DONE;
            end
            S_GET_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_GET_CAP;
            end
            S_GET_CAP: begin
                o_cmd.cap_val = 1'b1;
                o_cmd.set_ok  = 1'b1;
                n_state       = S_DONE;
            end
            S_DEL_RD: begin
                o_cmd.rd      = 1'b1;
                o_cmd.ptr_inc = 1'b1;
                n_state       = S_DEL_CAP;
            end
            S_DEL_CAP: begin
                o_cmd.cap_val = 1'b1;
                n_state       = i_sts.rd_last ? S_DEL_END : S_DN;
            end
            // close the gap: read each later element and write it one down
            S_DN: begin
                o_cmd.rd    = 1'b1;
                o_cmd.wr_dn = i_sts.rd_vld;
                if (i_sts.ptr_at_last) begin
                    n_state = S_DN_END;
                end else begin
                    o_cmd.ptr_inc = 1'b1;
                end
            end
            S_DN_END: begin
                o_cmd.wr_dn = 1'b1;
                n_state     = S_DEL_END;
            end
            S_DEL_END: begin
                o_cmd.cnt_dec = 1'b1;
                o_cmd.set_ok  = 1'b1;
                n_state       = S_DONE;
            end
            // scan from the head, stop at the first hit
            S_LOC: begin
                priority if (i_sts.match) begin
                    o_cmd.cap_pos = 1'b1;
                    n_state       = S_DONE;
                end else if (i_sts.ptr_at_last) begin
                    o_cmd.rd = 1'b1;
                    n_state  = S_LOC_END;
                end else begin
                    o_cmd.rd      = 1'b1;
                    o_cmd.ptr_inc = 1'b1;
                end
            end
            S_LOC_END: begin
                o_cmd.cap_pos = i_sts.match;
                n_state       = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
